// ----- design/register_vm_core_step_unit_assert.svh -----
// Assertion helpers used by the block's back sequencer (rvcs_back).
`ifndef REGISTER_VM_CORE_STEP_UNIT_ASSERT_SVH
`define REGISTER_VM_CORE_STEP_UNIT_ASSERT_SVH

// same-cycle implication
`define RVCS_ASSERT_IMP(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rvcs assertion failed");

// next-cycle implication
`define RVCS_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rvcs assertion failed");

`endif

// ----- design/rvcs_pkg.sv -----
package rvcs_pkg;

   localparam int CORES       = 4;
   localparam int CORE_W      = (CORES > 1) ? $clog2(CORES) : 1;
   localparam int RF_AW       = CORE_W + 4;
   localparam int RF_DEPTH    = CORES * 16;
   localparam int MEM_AW      = 16;
   localparam int MEM_DEPTH   = 1 << MEM_AW;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   localparam logic [2:0] CORE_COUNT_RESET = 3'd4;
   localparam logic [3:0] SP_IDX           = 4'd15;

   localparam logic [1:0] OP_STEP  = 2'd0;
   localparam logic [1:0] OP_WRITE = 2'd1;
   localparam logic [1:0] OP_READ  = 2'd2;

   localparam logic [1:0] FAULT_NONE    = 2'd0;
   localparam logic [1:0] FAULT_ILLEGAL = 2'd1;
   localparam logic [1:0] FAULT_DIV0    = 2'd2;
   localparam logic [1:0] FAULT_REQ     = 2'd3;

   localparam logic [7:0] OPC_NOP    = 8'd0;
   localparam logic [7:0] OPC_LDI    = 8'd1;
   localparam logic [7:0] OPC_LDHI   = 8'd2;
   localparam logic [7:0] OPC_SHL    = 8'd3;
   localparam logic [7:0] OPC_SHR    = 8'd4;
   localparam logic [7:0] OPC_SAR    = 8'd5;
   localparam logic [7:0] OPC_MOV    = 8'd6;
   localparam logic [7:0] OPC_ROT2   = 8'd7;
   localparam logic [7:0] OPC_ROT3   = 8'd8;
   localparam logic [7:0] OPC_ROT4   = 8'd9;
   localparam logic [7:0] OPC_ADD    = 8'd10;
   localparam logic [7:0] OPC_ADDI   = 8'd11;
   localparam logic [7:0] OPC_SUBI   = 8'd12;
   localparam logic [7:0] OPC_SUB    = 8'd13;
   localparam logic [7:0] OPC_MULU   = 8'd14;
   localparam logic [7:0] OPC_MULS   = 8'd15;
   localparam logic [7:0] OPC_DIVU   = 8'd16;
   localparam logic [7:0] OPC_DIVS   = 8'd17;
   localparam logic [7:0] OPC_LES    = 8'd18;
   localparam logic [7:0] OPC_LEU    = 8'd19;
   localparam logic [7:0] OPC_EQ     = 8'd20;
   localparam logic [7:0] OPC_JMP    = 8'd21;
   localparam logic [7:0] OPC_JREL   = 8'd22;
   localparam logic [7:0] OPC_JR     = 8'd23;
   localparam logic [7:0] OPC_JRREL  = 8'd24;
   localparam logic [7:0] OPC_SKZ    = 8'd25;
   localparam logic [7:0] OPC_SKNZ   = 8'd26;
   localparam logic [7:0] OPC_LD8    = 8'd27;
   localparam logic [7:0] OPC_LD16   = 8'd28;
   localparam logic [7:0] OPC_ST8    = 8'd29;
   localparam logic [7:0] OPC_ST16   = 8'd30;
   localparam logic [7:0] OPC_PUSH   = 8'd31;
   localparam logic [7:0] OPC_POP    = 8'd32;
   localparam logic [7:0] OPC_OUT    = 8'd33;
   localparam logic [7:0] OPC_IN     = 8'd34;
   localparam logic [7:0] OPC_CALLR  = 8'd35;
   localparam logic [7:0] OPC_CALL   = 8'd36;
   localparam logic [7:0] OPC_CALLRR = 8'd37;
   localparam logic [7:0] OPC_CALLRG = 8'd38;
   localparam logic [7:0] OPC_RET    = 8'd39;
   localparam logic [7:0] OPC_COREID = 8'd40;
   localparam logic [7:0] OPC_CORECNT = 8'd41;
   localparam logic [7:0] OPC_FAULT  = 8'd42;

   typedef enum logic [1:0] {
      KIND_STEP,
      KIND_WRITE,
      KIND_READ,
      KIND_NULL
   } kind_type;

   typedef struct packed {
      kind_type           kind;
      logic [CORE_W-1:0]  core;
      logic [15:0]        address;
      logic [7:0]         data;
      logic [15:0]        prd;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic not_empty;
   } q_status_type;

   typedef struct packed {
      logic [1:0]  fault_code;
      logic [15:0] next_pc;
      logic        executed;
      logic        port_write_valid;
      logic        port_read_valid;
      logic [7:0]  port_number;
      logic [15:0] port_write_data;
      logic [7:0]  mem_read_data;
   } res_type;

   typedef struct packed {
      logic        en;
      logic [3:0]  idx;
      logic [15:0] val;
   } reg_wr_type;

   typedef struct packed {
      logic        en;
      logic [15:0] addr;
      logic [7:0]  data;
   } mem_wr_type;

   typedef struct packed {
      logic        start;
      logic        sgn;
      logic [15:0] a;
      logic [15:0] b;
   } div_req_type;

   typedef struct packed {
      logic        done;
      logic [15:0] q;
      logic [15:0] r;
   } div_res_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_RDWAIT,
      ST_FETCH_B,
      ST_FETCH_C,
      ST_OPND,
      ST_EXEC,
      ST_LOAD,
      ST_DIV,
      ST_MEMWR,
      ST_REGWR,
      ST_COMMIT,
      ST_DONE
   } back_state_type;

   function automatic reg_wr_type mk_rw(input logic [3:0] idx, input logic [15:0] val);
      reg_wr_type w;
      w.en  = 1'b1;
      w.idx = idx;
      w.val = val;
      return w;
   endfunction

   function automatic mem_wr_type mk_mw(input logic [15:0] addr, input logic [7:0] data);
      mem_wr_type w;
      w.en   = 1'b1;
      w.addr = addr;
      w.data = data;
      return w;
   endfunction

   // register operand read order: r1, r2, r3, r4, then the stack pointer
   function automatic logic [3:0] operand_index(input logic [7:0] b, input logic [7:0] c,
                                                input logic [2:0] n);
      logic [3:0] idx;
      case (n)
         3'd0: idx = b[7:4];
         3'd1: idx = b[3:0];
         3'd2: idx = c[7:4];
         3'd3: idx = c[3:0];
         default: idx = SP_IDX;
      endcase
      return idx;
   endfunction

endpackage

// ----- design/rvcs_channels.sv -----
interface rvcs_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  op;
   logic [1:0]  core;
   logic [15:0] address;
   logic [7:0]  data;
   logic [15:0] port_read_data;

   modport source(output valid, output op, output core, output address, output data,
                  output port_read_data, input ready);
   modport sink(input valid, input op, input core, input address, input data,
                input port_read_data, output ready);
endinterface

interface rvcs_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  fault_code;
   logic [15:0] next_pc;
   logic        executed;
   logic        port_write_valid;
   logic        port_read_valid;
   logic [7:0]  port_number;
   logic [15:0] port_write_data;
   logic [7:0]  mem_read_data;

   modport source(output valid, output fault_code, output next_pc, output executed,
                  output port_write_valid, output port_read_valid, output port_number,
                  output port_write_data, output mem_read_data, input ready);
   modport sink(input valid, input fault_code, input next_pc, input executed,
                input port_write_valid, input port_read_valid, input port_number,
                input port_write_data, input mem_read_data, output ready);
endinterface

// ----- design/rvcs_front.sv -----
module rvcs_front (
   rvcs_req_if.sink               req_chan,
   input  logic                   clearing,
   input  rvcs_pkg::q_status_type q_stat,
   output logic                   push,
   output rvcs_pkg::cmd_type      push_cmd
);

   logic core_ok;

   assign req_chan.ready = !q_stat.full && !clearing;
   assign push           = req_chan.valid && req_chan.ready;
   assign core_ok        = 32'(req_chan.core) < rvcs_pkg::CORES;

   always_comb begin
      push_cmd.core    = rvcs_pkg::CORE_W'(req_chan.core);
      push_cmd.address = req_chan.address;
      push_cmd.data    = req_chan.data;
      push_cmd.prd     = req_chan.port_read_data;
      unique case (req_chan.op)
         rvcs_pkg::OP_STEP:  push_cmd.kind = core_ok ? rvcs_pkg::KIND_STEP : rvcs_pkg::KIND_NULL;
         rvcs_pkg::OP_WRITE: push_cmd.kind = rvcs_pkg::KIND_WRITE;
         rvcs_pkg::OP_READ:  push_cmd.kind = rvcs_pkg::KIND_READ;
         default:            push_cmd.kind = rvcs_pkg::KIND_NULL;
      endcase
   end

endmodule

// ----- design/rvcs_queue.sv -----
module rvcs_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  rvcs_pkg::cmd_type      push_cmd,
   input  logic                   pop,
   output rvcs_pkg::cmd_type      head,
   output rvcs_pkg::q_status_type q_stat
);

   rvcs_pkg::cmd_type          cmd_ff [rvcs_pkg::QUEUE_DEPTH];
   logic [rvcs_pkg::QPTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [rvcs_pkg::QPTR_W:0]   count_ff;

   assign head             = cmd_ff[rd_ptr_ff];
   assign q_stat.full      = count_ff == (rvcs_pkg::QPTR_W + 1)'(rvcs_pkg::QUEUE_DEPTH);
   assign q_stat.not_empty = count_ff != '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) wr_ptr_ff <= wr_ptr_ff + 1'b1;
         if (pop)  rd_ptr_ff <= rd_ptr_ff + 1'b1;
         if (push && !pop)      count_ff <= count_ff + 1'b1;
         else if (pop && !push) count_ff <= count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) cmd_ff[wr_ptr_ff] <= push_cmd;
   end

endmodule

// ----- design/rvcs_div.sv -----
module rvcs_div (
   input  logic                  clock,
   input  logic                  reset,
   input  rvcs_pkg::div_req_type req,
   output rvcs_pkg::div_res_type res
);

   logic        busy_ff, done_ff, negq_ff, negr_ff;
   logic [3:0]  cnt_ff;
   logic [15:0] quo_ff, rem_ff, dvs_ff;
   logic [16:0] shifted, diff;
   logic [15:0] mag_a, mag_b;

   assign mag_a   = (req.sgn && req.a[15]) ? 16'(-req.a) : req.a;
   assign mag_b   = (req.sgn && req.b[15]) ? 16'(-req.b) : req.b;
   assign shifted = {rem_ff, quo_ff[15]};
   assign diff    = shifted - {1'b0, dvs_ff};

   assign res.done = done_ff;
   assign res.q    = negq_ff ? 16'(-quo_ff) : quo_ff;
   assign res.r    = negr_ff ? 16'(-rem_ff) : rem_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (req.start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == 4'd15) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // restoring divide on magnitudes, one quotient bit a cycle
   always_ff @(posedge clock) begin
      if (req.start) begin
         quo_ff  <= mag_a;
         dvs_ff  <= mag_b;
         rem_ff  <= '0;
         negq_ff <= req.sgn && (req.a[15] ^ req.b[15]);
         negr_ff <= req.sgn && req.a[15];
      end else if (busy_ff) begin
         if (!diff[16]) begin
            rem_ff <= diff[15:0];
            quo_ff <= {quo_ff[14:0], 1'b1};
         end else begin
            rem_ff <= shifted[15:0];
            quo_ff <= {quo_ff[14:0], 1'b0};
         end
      end
   end

endmodule

// ----- design/rvcs_back.sv -----
`include "register_vm_core_step_unit_assert.svh"

module rvcs_back (
   input  logic                   clock,
   input  logic                   reset,
   input  logic [2:0]             core_count,
   input  rvcs_pkg::q_status_type q_stat,
   input  rvcs_pkg::cmd_type      q_head,
   output logic                   pop,
   output logic                   clearing,
   rvcs_rsp_if.source             rsp_chan
);

   rvcs_pkg::back_state_type state_ff, state_in;
   logic [2:0]  step_ff;
   logic [15:0] clr_cnt_ff;

   logic [15:0] pc_ff    [rvcs_pkg::CORES];
   logic [1:0]  fault_ff [rvcs_pkg::CORES];

   logic [7:0]  mem [rvcs_pkg::MEM_DEPTH];
   logic [7:0]  mem_q_ff;
   logic [15:0] rf  [rvcs_pkg::RF_DEPTH];
   logic [15:0] rf_q_ff;

   rvcs_pkg::cmd_type    cmd_ff;
   rvcs_pkg::res_type    res_ff, out_ff;
   logic                 out_valid_ff;
   logic [7:0]           opc_ff, b_ff, c_ff, ld_lo_ff;
   logic [15:0]          v_ff [5];
   rvcs_pkg::reg_wr_type wl_ff [4];
   rvcs_pkg::mem_wr_type ml_ff [2];
   logic [15:0]          pc_new_ff, ld_base_ff;
   logic [1:0]           fault_new_ff;

   logic                        mem_we, rf_we;
   logic [15:0]                 mem_addr;
   logic [7:0]                  mem_wd;
   logic [rvcs_pkg::RF_AW-1:0]  rf_waddr, rf_raddr;
   logic [15:0]                 rf_wd;
   logic                        out_free;
   logic [15:0]                 pc_cur, ld_word;

   rvcs_pkg::div_req_type div_req;
   rvcs_pkg::div_res_type div_res;

   // execute decode
   rvcs_pkg::reg_wr_type ex_wl [4];
   rvcs_pkg::mem_wr_type ex_ml [2];
   logic [15:0]          ex_pc, ex_base, ex_pwd;
   logic [1:0]           ex_fault;
   logic                 ex_pwv, ex_prv, ex_t, ex_is_div, ex_is_load, ex_sgn;
   logic [7:0]           ex_pnum;
   logic [31:0]          ex_sum;
   logic signed [33:0]   ex_prod;
   logic signed [15:0]   ex_sra;
   logic [3:0]           i1, i2, i3, i4, ex_n;
   logic [15:0]          v1, v2, v3, v4, v15, d, sp_inc, sp_dec;

   assign pc_cur   = pc_ff[cmd_ff.core];
   assign out_free = !out_valid_ff || rsp_chan.ready;
   assign clearing = state_ff == rvcs_pkg::ST_CLEAR;
   assign pop      = state_ff == rvcs_pkg::ST_IDLE && q_stat.not_empty;
   assign ld_word  = {mem_q_ff, ld_lo_ff};

   assign i1  = b_ff[7:4];
   assign i2  = b_ff[3:0];
   assign i3  = c_ff[7:4];
   assign i4  = c_ff[3:0];
   assign v1  = v_ff[0];
   assign v2  = v_ff[1];
   assign v3  = v_ff[2];
   assign v4  = v_ff[3];
   assign v15 = v_ff[4];
   assign d      = {b_ff, c_ff};
   assign sp_inc = v15 + 16'd2;
   assign sp_dec = v15 - 16'd2;

   assign ex_is_div  = opc_ff == rvcs_pkg::OPC_DIVU || opc_ff == rvcs_pkg::OPC_DIVS;
   assign ex_is_load = opc_ff == rvcs_pkg::OPC_LD8 || opc_ff == rvcs_pkg::OPC_LD16 ||
                       opc_ff == rvcs_pkg::OPC_POP || opc_ff == rvcs_pkg::OPC_RET;
   assign ex_sgn     = opc_ff == rvcs_pkg::OPC_MULS;
   assign ex_prod    = $signed({ex_sgn & v3[15], v3}) * $signed({ex_sgn & v4[15], v4});
   assign ex_n       = (|v2[15:4]) ? 4'd15 : v2[3:0];
   assign ex_sra     = $signed(v1) >>> ex_n;

   assign div_req.start = state_ff == rvcs_pkg::ST_EXEC && ex_is_div && v4 != '0;
   assign div_req.sgn   = opc_ff == rvcs_pkg::OPC_DIVS;
   assign div_req.a     = v3;
   assign div_req.b     = v4;

   rvcs_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .res   (div_res)
   );

   always_comb begin
      ex_wl    = '{default: '0};
      ex_ml    = '{default: '0};
      ex_pc    = pc_cur + 16'd3;
      ex_fault = rvcs_pkg::FAULT_NONE;
      ex_pwv   = 1'b0;
      ex_prv   = 1'b0;
      ex_pnum  = '0;
      ex_pwd   = '0;
      ex_base  = v2;
      ex_sum   = '0;
      ex_t     = 1'b0;
      unique case (opc_ff)
         rvcs_pkg::OPC_NOP: ;
         rvcs_pkg::OPC_LDI:  ex_wl[0] = rvcs_pkg::mk_rw(i1, {8'h00, c_ff});
         rvcs_pkg::OPC_LDHI: ex_wl[0] = rvcs_pkg::mk_rw(i1, {v1[7:0], c_ff});
         rvcs_pkg::OPC_SHL:  ex_wl[0] = rvcs_pkg::mk_rw(i1, (|v2[15:4]) ? '0 : v1 << v2[3:0]);
         rvcs_pkg::OPC_SHR:  ex_wl[0] = rvcs_pkg::mk_rw(i1, (|v2[15:4]) ? '0 : v1 >> v2[3:0]);
         rvcs_pkg::OPC_SAR:  ex_wl[0] = rvcs_pkg::mk_rw(i1, ex_sra);
         rvcs_pkg::OPC_MOV:  ex_wl[0] = rvcs_pkg::mk_rw(i1, v2);
         rvcs_pkg::OPC_ROT2: begin
            ex_wl[0] = rvcs_pkg::mk_rw(i1, v2);
            ex_wl[1] = rvcs_pkg::mk_rw(i2, v1);
         end
         rvcs_pkg::OPC_ROT3: begin
            ex_wl[0] = rvcs_pkg::mk_rw(i1, v2);
            ex_wl[1] = rvcs_pkg::mk_rw(i2, v3);
            ex_wl[2] = rvcs_pkg::mk_rw(i3, v1);
         end
         rvcs_pkg::OPC_ROT4: begin
            ex_wl[0] = rvcs_pkg::mk_rw(i1, v2);
            ex_wl[1] = rvcs_pkg::mk_rw(i2, v3);
            ex_wl[2] = rvcs_pkg::mk_rw(i3, v4);
            ex_wl[3] = rvcs_pkg::mk_rw(i4, v1);
         end
         rvcs_pkg::OPC_ADD: begin
            ex_sum   = {16'h0000, v3} + {16'h0000, v4};
            ex_wl[0] = rvcs_pkg::mk_rw(i1, ex_sum[31:16]);
            ex_wl[1] = rvcs_pkg::mk_rw(i2, ex_sum[15:0]);
         end
         rvcs_pkg::OPC_ADDI: begin
            ex_sum   = {16'h0000, v2} + {24'h000000, c_ff};
            ex_wl[0] = rvcs_pkg::mk_rw(i1, ex_sum[31:16]);
            ex_wl[1] = rvcs_pkg::mk_rw(i2, ex_sum[15:0]);
         end
         rvcs_pkg::OPC_SUBI: begin
            ex_sum   = {16'h0000, v2} - {24'h000000, c_ff};
            ex_wl[0] = rvcs_pkg::mk_rw(i1, ex_sum[31:16]);
            ex_wl[1] = rvcs_pkg::mk_rw(i2, ex_sum[15:0]);
         end
         rvcs_pkg::OPC_SUB: begin
            ex_sum   = {16'h0000, v3} - {16'h0000, v4};
            ex_wl[0] = rvcs_pkg::mk_rw(i1, ex_sum[31:16]);
            ex_wl[1] = rvcs_pkg::mk_rw(i2, ex_sum[15:0]);
         end
         rvcs_pkg::OPC_MULU: begin
            ex_wl[0] = rvcs_pkg::mk_rw(i1, ex_prod[31:16]);
            ex_wl[1] = rvcs_pkg::mk_rw(i2, ex_prod[15:0]);
         end
         rvcs_pkg::OPC_MULS: begin
            ex_wl[0] = rvcs_pkg::mk_rw(i1, ex_prod[31:16]);
            ex_wl[1] = rvcs_pkg::mk_rw(i2, ex_prod[15:0]);
         end
         rvcs_pkg::OPC_DIVU: begin
            if (v4 == '0) begin
               ex_fault = rvcs_pkg::FAULT_DIV0;
               ex_pc    = pc_cur;
            end
         end
         rvcs_pkg::OPC_DIVS: begin
            if (v4 == '0) begin
               ex_fault = rvcs_pkg::FAULT_DIV0;
               ex_pc    = pc_cur;
            end
         end
         rvcs_pkg::OPC_LES: begin
            ex_t     = $signed(v3) <= $signed(v4);
            ex_wl[0] = rvcs_pkg::mk_rw(i1, {15'd0, ex_t});
            ex_wl[1] = rvcs_pkg::mk_rw(i2, {15'd0, !ex_t});
         end
         rvcs_pkg::OPC_LEU: begin
            ex_t     = v3 <= v4;
            ex_wl[0] = rvcs_pkg::mk_rw(i1, {15'd0, ex_t});
            ex_wl[1] = rvcs_pkg::mk_rw(i2, {15'd0, !ex_t});
         end
         rvcs_pkg::OPC_EQ: begin
            ex_t     = v3 == v4;
            ex_wl[0] = rvcs_pkg::mk_rw(i1, {15'd0, ex_t});
            ex_wl[1] = rvcs_pkg::mk_rw(i2, {15'd0, !ex_t});
         end
         rvcs_pkg::OPC_JMP:   ex_pc = d;
         rvcs_pkg::OPC_JREL:  ex_pc = pc_cur + d;
         rvcs_pkg::OPC_JR:    ex_pc = v1;
         rvcs_pkg::OPC_JRREL: ex_pc = pc_cur + v1;
         rvcs_pkg::OPC_SKZ:   if (v1 == '0) ex_pc = pc_cur + 16'd6;
         rvcs_pkg::OPC_SKNZ:  if (v1 != '0) ex_pc = pc_cur + 16'd6;
         rvcs_pkg::OPC_LD8:   ex_base = v2;
         rvcs_pkg::OPC_LD16:  ex_base = v2;
         rvcs_pkg::OPC_ST8:   ex_ml[0] = rvcs_pkg::mk_mw(v1, v2[7:0]);
         rvcs_pkg::OPC_ST16: begin
            ex_ml[0] = rvcs_pkg::mk_mw(v1, v2[7:0]);
            ex_ml[1] = rvcs_pkg::mk_mw(v1 + 16'd1, v2[15:8]);
         end
         rvcs_pkg::OPC_PUSH: begin
            ex_wl[0] = rvcs_pkg::mk_rw(rvcs_pkg::SP_IDX, sp_inc);
            ex_ml[0] = rvcs_pkg::mk_mw(sp_inc + 16'd1, v1[15:8]);
            ex_ml[1] = rvcs_pkg::mk_mw(sp_inc, v1[7:0]);
         end
         rvcs_pkg::OPC_POP: begin
            ex_base  = v15;
            ex_wl[0] = rvcs_pkg::mk_rw(rvcs_pkg::SP_IDX, sp_dec);
         end
         rvcs_pkg::OPC_OUT: begin
            ex_pwv  = 1'b1;
            ex_pnum = c_ff;
            ex_pwd  = v1;
         end
         rvcs_pkg::OPC_IN: begin
            ex_prv   = 1'b1;
            ex_pnum  = c_ff;
            ex_wl[0] = rvcs_pkg::mk_rw(i1, cmd_ff.prd);
         end
         rvcs_pkg::OPC_CALLR: begin
            ex_wl[0] = rvcs_pkg::mk_rw(rvcs_pkg::SP_IDX, sp_inc);
            ex_ml[0] = rvcs_pkg::mk_mw(sp_inc + 16'd1, pc_cur[15:8]);
            ex_ml[1] = rvcs_pkg::mk_mw(sp_inc, pc_cur[7:0]);
            ex_pc    = pc_cur + d;
         end
         rvcs_pkg::OPC_CALL: begin
            ex_wl[0] = rvcs_pkg::mk_rw(rvcs_pkg::SP_IDX, sp_inc);
            ex_ml[0] = rvcs_pkg::mk_mw(sp_inc + 16'd1, pc_cur[15:8]);
            ex_ml[1] = rvcs_pkg::mk_mw(sp_inc, pc_cur[7:0]);
            ex_pc    = d;
         end
         rvcs_pkg::OPC_CALLRR: begin
            ex_wl[0] = rvcs_pkg::mk_rw(rvcs_pkg::SP_IDX, sp_inc);
            ex_ml[0] = rvcs_pkg::mk_mw(sp_inc + 16'd1, pc_cur[15:8]);
            ex_ml[1] = rvcs_pkg::mk_mw(sp_inc, pc_cur[7:0]);
            ex_pc    = pc_cur + v1;
         end
         rvcs_pkg::OPC_CALLRG: begin
            ex_wl[0] = rvcs_pkg::mk_rw(rvcs_pkg::SP_IDX, sp_inc);
            ex_ml[0] = rvcs_pkg::mk_mw(sp_inc + 16'd1, pc_cur[15:8]);
            ex_ml[1] = rvcs_pkg::mk_mw(sp_inc, pc_cur[7:0]);
            ex_pc    = v1;
         end
         rvcs_pkg::OPC_RET: begin
            ex_base  = v15;
            ex_wl[0] = rvcs_pkg::mk_rw(rvcs_pkg::SP_IDX, sp_dec);
         end
         rvcs_pkg::OPC_COREID:  ex_wl[0] = rvcs_pkg::mk_rw(i1, 16'(cmd_ff.core));
         rvcs_pkg::OPC_CORECNT: ex_wl[0] = rvcs_pkg::mk_rw(i1, {13'd0, core_count});
         rvcs_pkg::OPC_FAULT: begin
            ex_fault = rvcs_pkg::FAULT_REQ;
            ex_pc    = pc_cur;
         end
         default: begin
            ex_fault = rvcs_pkg::FAULT_ILLEGAL;
            ex_pc    = pc_cur;
         end
      endcase
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         rvcs_pkg::ST_CLEAR: if (clr_cnt_ff == '1) state_in = rvcs_pkg::ST_IDLE;
         rvcs_pkg::ST_IDLE: begin
            if (q_stat.not_empty) begin
               unique case (q_head.kind)
                  rvcs_pkg::KIND_READ: state_in = rvcs_pkg::ST_RDWAIT;
                  rvcs_pkg::KIND_STEP: begin
                     if (fault_ff[q_head.core] != rvcs_pkg::FAULT_NONE)
                        state_in = rvcs_pkg::ST_DONE;
                     else
                        state_in = rvcs_pkg::ST_FETCH_B;
                  end
                  default: state_in = rvcs_pkg::ST_DONE;
               endcase
            end
         end
         rvcs_pkg::ST_RDWAIT:  state_in = rvcs_pkg::ST_DONE;
         rvcs_pkg::ST_FETCH_B: state_in = rvcs_pkg::ST_FETCH_C;
         rvcs_pkg::ST_FETCH_C: state_in = rvcs_pkg::ST_OPND;
         rvcs_pkg::ST_OPND:    if (step_ff == 3'd5) state_in = rvcs_pkg::ST_EXEC;
         rvcs_pkg::ST_EXEC: begin
            if (div_req.start)   state_in = rvcs_pkg::ST_DIV;
            else if (ex_is_load) state_in = rvcs_pkg::ST_LOAD;
            else                 state_in = rvcs_pkg::ST_MEMWR;
         end
         rvcs_pkg::ST_LOAD:   if (step_ff == 3'd2) state_in = rvcs_pkg::ST_MEMWR;
         rvcs_pkg::ST_DIV:    if (div_res.done) state_in = rvcs_pkg::ST_MEMWR;
         rvcs_pkg::ST_MEMWR:  if (step_ff == 3'd1) state_in = rvcs_pkg::ST_REGWR;
         rvcs_pkg::ST_REGWR:  if (step_ff == 3'd3) state_in = rvcs_pkg::ST_COMMIT;
         rvcs_pkg::ST_COMMIT: state_in = rvcs_pkg::ST_DONE;
         rvcs_pkg::ST_DONE:   if (out_free) state_in = rvcs_pkg::ST_IDLE;
         default:             state_in = rvcs_pkg::ST_IDLE;
      endcase
   end

   // memory and register file ports
   always_comb begin
      mem_we   = 1'b0;
      mem_addr = '0;
      mem_wd   = '0;
      rf_we    = 1'b0;
      rf_waddr = '0;
      rf_wd    = '0;
      rf_raddr = {cmd_ff.core, rvcs_pkg::operand_index(b_ff, c_ff, step_ff)};
      unique case (state_ff)
         rvcs_pkg::ST_CLEAR: begin
            mem_we   = 1'b1;
            mem_addr = clr_cnt_ff;
            rf_we    = {1'b0, clr_cnt_ff} < 17'(rvcs_pkg::RF_DEPTH);
            rf_waddr = clr_cnt_ff[rvcs_pkg::RF_AW-1:0];
         end
         rvcs_pkg::ST_IDLE: begin
            if (q_head.kind == rvcs_pkg::KIND_STEP) begin
               mem_addr = pc_ff[q_head.core];
            end else begin
               mem_addr = q_head.address;
               mem_wd   = q_head.data;
               mem_we   = q_stat.not_empty && q_head.kind == rvcs_pkg::KIND_WRITE;
            end
         end
         rvcs_pkg::ST_FETCH_B: mem_addr = pc_cur + 16'd1;
         rvcs_pkg::ST_FETCH_C: mem_addr = pc_cur + 16'd2;
         rvcs_pkg::ST_LOAD:    mem_addr = (step_ff == 3'd0) ? ld_base_ff : ld_base_ff + 16'd1;
         rvcs_pkg::ST_MEMWR: begin
            mem_we   = ml_ff[step_ff[0]].en;
            mem_addr = ml_ff[step_ff[0]].addr;
            mem_wd   = ml_ff[step_ff[0]].data;
         end
         rvcs_pkg::ST_REGWR: begin
            rf_we    = wl_ff[step_ff[1:0]].en;
            rf_waddr = {cmd_ff.core, wl_ff[step_ff[1:0]].idx};
            rf_wd    = wl_ff[step_ff[1:0]].val;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_addr] <= mem_wd;
      mem_q_ff <= mem[mem_addr];
   end

   always_ff @(posedge clock) begin
      if (rf_we) rf[rf_waddr] <= rf_wd;
      rf_q_ff <= rf[rf_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rvcs_pkg::ST_CLEAR;
         step_ff      <= '0;
         clr_cnt_ff   <= '0;
         out_valid_ff <= 1'b0;
         pc_ff        <= '{default: '0};
         fault_ff     <= '{default: rvcs_pkg::FAULT_NONE};
      end else begin
         state_ff <= state_in;
         step_ff  <= (state_in != state_ff) ? 3'd0 : step_ff + 3'd1;
         if (state_ff == rvcs_pkg::ST_CLEAR) clr_cnt_ff <= clr_cnt_ff + 16'd1;
         if (state_ff == rvcs_pkg::ST_COMMIT) begin
            pc_ff[cmd_ff.core]    <= pc_new_ff;
            fault_ff[cmd_ff.core] <= fault_new_ff;
         end
         if (state_ff == rvcs_pkg::ST_DONE && out_free) out_valid_ff <= 1'b1;
         else if (rsp_chan.ready)                       out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      unique case (state_ff)
         rvcs_pkg::ST_IDLE: begin
            if (q_stat.not_empty) begin
               cmd_ff <= q_head;
               res_ff <= '0;
               if (q_head.kind == rvcs_pkg::KIND_STEP) begin
                  res_ff.fault_code <= fault_ff[q_head.core];
                  res_ff.next_pc    <= pc_ff[q_head.core];
               end
            end
         end
         rvcs_pkg::ST_RDWAIT:  res_ff.mem_read_data <= mem_q_ff;
         rvcs_pkg::ST_FETCH_B: opc_ff <= mem_q_ff;
         rvcs_pkg::ST_FETCH_C: b_ff <= mem_q_ff;
         rvcs_pkg::ST_OPND: begin
            if (step_ff == 3'd0) c_ff <= mem_q_ff;
            else                 v_ff[step_ff - 3'd1] <= rf_q_ff;
         end
         rvcs_pkg::ST_EXEC: begin
            wl_ff        <= ex_wl;
            ml_ff        <= ex_ml;
            pc_new_ff    <= ex_pc;
            fault_new_ff <= ex_fault;
            ld_base_ff   <= ex_base;
            res_ff.port_write_valid <= ex_pwv;
            res_ff.port_read_valid  <= ex_prv;
            res_ff.port_number      <= ex_pnum;
            res_ff.port_write_data  <= ex_pwd;
         end
         rvcs_pkg::ST_LOAD: begin
            if (step_ff == 3'd1) ld_lo_ff <= mem_q_ff;
            if (step_ff == 3'd2) begin
               unique case (opc_ff)
                  rvcs_pkg::OPC_LD8:  wl_ff[0] <= rvcs_pkg::mk_rw(i1, {8'h00, ld_lo_ff});
                  rvcs_pkg::OPC_LD16: wl_ff[0] <= rvcs_pkg::mk_rw(i1, ld_word);
                  rvcs_pkg::OPC_POP:  wl_ff[1] <= rvcs_pkg::mk_rw(i1, ld_word);
                  default:            pc_new_ff <= ld_word + 16'd3;
               endcase
            end
         end
         rvcs_pkg::ST_DIV: begin
            if (div_res.done) begin
               wl_ff[0] <= rvcs_pkg::mk_rw(i1, div_res.q);
               wl_ff[1] <= rvcs_pkg::mk_rw(i2, div_res.r);
            end
         end
         rvcs_pkg::ST_COMMIT: begin
            res_ff.fault_code <= fault_new_ff;
            res_ff.next_pc    <= pc_new_ff;
            res_ff.executed   <= 1'b1;
         end
         default: ;
      endcase
      if (state_ff == rvcs_pkg::ST_DONE && out_free) out_ff <= res_ff;
   end

   assign rsp_chan.valid            = out_valid_ff;
   assign rsp_chan.fault_code       = out_ff.fault_code;
   assign rsp_chan.next_pc          = out_ff.next_pc;
   assign rsp_chan.executed         = out_ff.executed;
   assign rsp_chan.port_write_valid = out_ff.port_write_valid;
   assign rsp_chan.port_read_valid  = out_ff.port_read_valid;
   assign rsp_chan.port_number      = out_ff.port_number;
   assign rsp_chan.port_write_data  = out_ff.port_write_data;
   assign rsp_chan.mem_read_data    = out_ff.mem_read_data;

   `RVCS_ASSERT_IMP(a_div_done_in_div, clock, reset, div_res.done, state_ff == rvcs_pkg::ST_DIV)
   `RVCS_ASSERT_NEXT(a_done_loads_out, clock, reset, state_ff == rvcs_pkg::ST_DONE && out_free, out_valid_ff)
   `RVCS_ASSERT_IMP(a_commit_unfaulted, clock, reset, state_ff == rvcs_pkg::ST_COMMIT, fault_ff[cmd_ff.core] == rvcs_pkg::FAULT_NONE)

endmodule

// ----- design/register_vm_core_step_unit.sv -----
// Multi-core register machine step unit.
// req_chan carries one word per item: step a core, write a memory byte or read one.
// rsp_chan returns exactly one word per item, in order. csr_we/csr_wdata set the
// core count that the count-cores instruction reports; write only while idle.
// A front stage classifies words into a two-word queue; the back sequencer
// serves one item at a time over a single-port byte memory and a register file
// with one read and one write port. Fetch, loads and stores pass in turn
// through the one memory port, and divides use an iterative divider; the
// sequencer takes no new item until the last result is in the output register.
// After reset the memory and registers are cleared, one byte a cycle, over
// every memory address; req_chan.ready stays low during that pass.
// A stalled receiver holds the result in the output register; the sequencer
// may finish one more item and the queue takes two more before ready drops.
module register_vm_core_step_unit (
   input  logic       clock,
   input  logic       reset,
   rvcs_req_if.sink   req_chan,
   rvcs_rsp_if.source rsp_chan,
   input  logic       csr_we,
   input  logic [2:0] csr_wdata
);

   logic                   core_count_ff;
   logic [2:0]             core_count_q_ff;
   logic                   push, pop, clearing;
   rvcs_pkg::cmd_type      push_cmd, q_head;
   rvcs_pkg::q_status_type q_stat;

   always_ff @(posedge clock) begin
      if (reset) begin
         core_count_q_ff <= rvcs_pkg::CORE_COUNT_RESET;
         core_count_ff   <= 1'b0;
      end else if (csr_we) begin
         core_count_q_ff <= csr_wdata;
         core_count_ff   <= 1'b1;
      end
   end

   rvcs_front u_front (
      .req_chan (req_chan),
      .clearing (clearing),
      .q_stat   (q_stat),
      .push     (push),
      .push_cmd (push_cmd)
   );

   rvcs_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .head     (q_head),
      .q_stat   (q_stat)
   );

   rvcs_back u_back (
      .clock      (clock),
      .reset      (reset),
      .core_count (core_count_q_ff),
      .q_stat     (q_stat),
      .q_head     (q_head),
      .pop        (pop),
      .clearing   (clearing),
      .rsp_chan   (rsp_chan)
   );

endmodule

// ----- verif/rvcs_step_checker.sv -----
`timescale 1ns / 1ps
module rvcs_step_checker
   import rvcs_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   rvcs_req_if              req_mon,
   rvcs_rsp_if              rsp_mon,
   input  logic             csr_we,
   input  logic [2:0]       csr_wdata,
   output int               failures,
   output int               backlog,
   output logic [3:0][15:0] pc_view
);

   logic [15:0] gpr [4][16];
   logic [15:0] core_pc [4];
   logic [1:0]  core_fault [4];
   logic [7:0]  mem [65536];
   logic [2:0]  core_count;
   res_type     expected_words [$];

   task automatic push_word(input int k, input logic [15:0] val);
      logic [15:0] sp;
      sp = gpr[k][15] + 16'd2;
      gpr[k][15] = sp;
      mem[sp + 16'd1] = val[15:8];
      mem[sp] = val[7:0];
   endtask

   task automatic pop_word(input int k, output logic [15:0] val);
      logic [15:0] sp;
      sp = gpr[k][15];
      val = {mem[sp + 16'd1], mem[sp]};
      gpr[k][15] = sp - 16'd2;
   endtask

   task automatic run_step(input int k, input logic [15:0] prd, inout res_type r);
      logic [15:0] pc, v1, v2, v3, v4, d, t;
      logic [7:0]  opc, b, c;
      logic [3:0]  i1, i2, i3, i4;
      logic signed [15:0] s;
      logic [31:0] wide;
      int          sa, sb;
      logic        adv;
      pc = core_pc[k];
      if (core_fault[k] != FAULT_NONE) begin
         r.fault_code = core_fault[k];
         r.next_pc = pc;
         return;
      end
      opc = mem[pc];
      b = mem[pc + 16'd1];
      c = mem[pc + 16'd2];
      i1 = b[7:4]; i2 = b[3:0]; i3 = c[7:4]; i4 = c[3:0];
      v1 = gpr[k][i1]; v2 = gpr[k][i2]; v3 = gpr[k][i3]; v4 = gpr[k][i4];
      d = {b, c};
      sa = $signed(v3);
      sb = $signed(v4);
      adv = 1'b1;
      r.executed = 1'b1;
      case (opc)
         OPC_NOP: ;
         OPC_LDI: gpr[k][i1] = {8'd0, c};
         OPC_LDHI: gpr[k][i1] = {v1[7:0], c};
         OPC_SHL: gpr[k][i1] = (v2 >= 16) ? 16'd0 : v1 << v2;
         OPC_SHR: gpr[k][i1] = (v2 >= 16) ? 16'd0 : v1 >> v2;
         OPC_SAR: begin
            s = v1;
            gpr[k][i1] = s >>> ((v2 >= 16) ? 15 : v2);
         end
         OPC_MOV: gpr[k][i1] = v2;
         OPC_ROT2: begin gpr[k][i1] = v2; gpr[k][i2] = v1; end
         OPC_ROT3: begin gpr[k][i1] = v2; gpr[k][i2] = v3; gpr[k][i3] = v1; end
         OPC_ROT4: begin
            gpr[k][i1] = v2; gpr[k][i2] = v3; gpr[k][i3] = v4; gpr[k][i4] = v1;
         end
         OPC_ADD, OPC_ADDI, OPC_SUBI, OPC_SUB, OPC_MULU, OPC_MULS: begin
            case (opc)
               OPC_ADD:  wide = {16'd0, v3} + {16'd0, v4};
               OPC_ADDI: wide = {16'd0, v2} + {24'd0, c};
               OPC_SUBI: wide = {16'd0, v2} - {24'd0, c};
               OPC_SUB:  wide = {16'd0, v3} - {16'd0, v4};
               OPC_MULU: wide = {16'd0, v3} * {16'd0, v4};
               default:  wide = sa * sb;
            endcase
            gpr[k][i1] = wide[31:16];
            gpr[k][i2] = wide[15:0];
         end
         OPC_DIVU, OPC_DIVS: begin
            if (v4 == 16'd0) core_fault[k] = FAULT_DIV0;
            else if (opc == OPC_DIVU) begin
               gpr[k][i1] = v3 / v4;
               gpr[k][i2] = v3 % v4;
            end else begin
               // -32768 / -1 wraps back to 0x8000
               gpr[k][i1] = 16'(sa / sb);
               gpr[k][i2] = 16'(sa % sb);
            end
         end
         OPC_LES, OPC_LEU, OPC_EQ: begin
            case (opc)
               OPC_LES: t = {15'd0, sa <= sb};
               OPC_LEU: t = {15'd0, v3 <= v4};
               default: t = {15'd0, v3 == v4};
            endcase
            gpr[k][i1] = t;
            gpr[k][i2] = {15'd0, ~t[0]};
         end
         OPC_JMP:   begin pc = d; adv = 1'b0; end
         OPC_JREL:  begin pc = pc + d; adv = 1'b0; end
         OPC_JR:    begin pc = v1; adv = 1'b0; end
         OPC_JRREL: begin pc = pc + v1; adv = 1'b0; end
         OPC_SKZ:   if (v1 == 16'd0) pc = pc + 16'd3;
         OPC_SKNZ:  if (v1 != 16'd0) pc = pc + 16'd3;
         OPC_LD8:   gpr[k][i1] = {8'd0, mem[v2]};
         OPC_LD16:  gpr[k][i1] = {mem[v2 + 16'd1], mem[v2]};
         OPC_ST8:   mem[v1] = v2[7:0];
         OPC_ST16: begin
            mem[v1] = v2[7:0];
            mem[v1 + 16'd1] = v2[15:8];
         end
         OPC_PUSH: push_word(k, v1);
         OPC_POP: begin pop_word(k, t); gpr[k][i1] = t; end
         OPC_OUT: begin
            r.port_write_valid = 1'b1;
            r.port_number = c;
            r.port_write_data = v1;
         end
         OPC_IN: begin
            r.port_read_valid = 1'b1;
            r.port_number = c;
            gpr[k][i1] = prd;
         end
         OPC_CALLR:  begin push_word(k, pc); pc = pc + d; adv = 1'b0; end
         OPC_CALL:   begin push_word(k, pc); pc = d; adv = 1'b0; end
         OPC_CALLRR: begin push_word(k, pc); pc = pc + v1; adv = 1'b0; end
         OPC_CALLRG: begin push_word(k, pc); pc = v1; adv = 1'b0; end
         OPC_RET:     pop_word(k, pc);
         OPC_COREID:  gpr[k][i1] = 16'(k);
         OPC_CORECNT: gpr[k][i1] = {13'd0, core_count};
         OPC_FAULT:   core_fault[k] = FAULT_REQ;
         default: begin core_fault[k] = FAULT_ILLEGAL; adv = 1'b0; end
      endcase
      if (core_fault[k] == FAULT_NONE && adv) pc = pc + 16'd3;
      core_pc[k] = pc;
      r.fault_code = core_fault[k];
      r.next_pc = pc;
   endtask

   function automatic int field_diff(input string name, input logic [15:0] want,
                                     input logic [15:0] got);
      if (want === got) return 0;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      return 1;
   endfunction

   always @(posedge clock) begin
      res_type want, got;
      int      bad;
      if (reset) begin
         for (int k = 0; k < 4; k++) begin
            for (int i = 0; i < 16; i++) gpr[k][i] = 16'd0;
            core_pc[k] = 16'd0;
            core_fault[k] = FAULT_NONE;
         end
         for (int a = 0; a < 65536; a++) mem[a] = 8'd0;
         core_count = CORE_COUNT_RESET;
         expected_words.delete();
         failures = 0;
      end else begin
         if (csr_we) core_count = csr_wdata;
         if (req_mon.valid && req_mon.ready) begin
            want = '0;
            case (req_mon.op)
               OP_STEP:  run_step(req_mon.core, req_mon.port_read_data, want);
               OP_WRITE: mem[req_mon.address] = req_mon.data;
               OP_READ:  want.mem_read_data = mem[req_mon.address];
               default: ;
            endcase
            expected_words.push_back(want);
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            got.fault_code = rsp_mon.fault_code;
            got.next_pc = rsp_mon.next_pc;
            got.executed = rsp_mon.executed;
            got.port_write_valid = rsp_mon.port_write_valid;
            got.port_read_valid = rsp_mon.port_read_valid;
            got.port_number = rsp_mon.port_number;
            got.port_write_data = rsp_mon.port_write_data;
            got.mem_read_data = rsp_mon.mem_read_data;
            if (expected_words.size() == 0) begin
               $display("%0t: unexpected result word, expected none, actual %h", $time, got);
               failures++;
            end else begin
               want = expected_words.pop_front();
               bad = field_diff("fault_code", want.fault_code, got.fault_code)
                   + field_diff("next_pc", want.next_pc, got.next_pc)
                   + field_diff("executed", want.executed, got.executed)
                   + field_diff("port_write_valid", want.port_write_valid,
                                got.port_write_valid)
                   + field_diff("port_read_valid", want.port_read_valid,
                                got.port_read_valid)
                   + field_diff("port_number", want.port_number, got.port_number)
                   + field_diff("port_write_data", want.port_write_data,
                                got.port_write_data)
                   + field_diff("mem_read_data", want.mem_read_data, got.mem_read_data);
               if (bad != 0) failures++;
            end
         end
      end
      backlog = expected_words.size();
      for (int k = 0; k < 4; k++) pc_view[k] = core_pc[k];
   end

endmodule

// ----- verif/tb_register_vm_core_step_unit.sv -----
`timescale 1ns / 1ps
module tb_register_vm_core_step_unit;
   import rvcs_pkg::*;

   localparam int WATCHDOG_LIMIT = 150000;
   localparam int ITEM_TARGET    = 450;

   logic             clock;
   logic             reset;
   logic             csr_we;
   logic [2:0]       csr_wdata;
   int               failures;
   int               backlog;
   logic [3:0][15:0] pc_now;
   int               in_flight;
   int               quiet_cycles;
   int               sent;
   bit               calm;
   bit               hold_request;

   rvcs_req_if req_if ();
   rvcs_rsp_if rsp_if ();

   register_vm_core_step_unit DUT (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_if),
      .rsp_chan  (rsp_if),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   rvcs_step_checker checker_i (
      .clock     (clock),
      .reset     (reset),
      .req_mon   (req_if),
      .rsp_mon   (rsp_if),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .failures  (failures),
      .backlog   (backlog),
      .pc_view   (pc_now)
   );

   always #4 clock = ~clock;

   always @(posedge clock) begin
      if (reset) begin
         in_flight <= 0;
         quiet_cycles <= 0;
      end else begin
         in_flight <= in_flight + int'(req_if.valid && req_if.ready)
                                - int'(rsp_if.valid && rsp_if.ready);
         if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
            quiet_cycles <= 0;
         else
            quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("simulation failed");
            $finish;
         end
      end
   end

   // result side back-pressure
   initial begin
      rsp_if.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_if.ready <= 1'b0;
            repeat (400) @(posedge clock);
         end else if (!calm && $urandom_range(0, 5) == 0) begin
            rsp_if.ready <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clock);
         end else begin
            rsp_if.ready <= 1'b1;
            repeat ($urandom_range(1, 40)) @(posedge clock);
         end
      end
   end

   task automatic send_word(input logic [1:0] op, input logic [1:0] k,
                            input logic [15:0] addr, input logic [7:0] data,
                            input logic [15:0] prd);
      if (!calm && $urandom_range(0, 7) == 0) begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(1, 17)) @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.op <= op;
      req_if.core <= k;
      req_if.address <= addr;
      req_if.data <= data;
      req_if.port_read_data <= prd;
      do @(posedge clock); while (!req_if.ready);
      sent++;
   endtask

   task automatic drain();
      req_if.valid <= 1'b0;
      do @(posedge clock); while (in_flight != 0);
   endtask

   task automatic write_core_count(input logic [2:0] val);
      drain();
      csr_we <= 1'b1;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // lay the three instruction bytes at pc, then step the core
   task automatic put_instr(input logic [1:0] k, input logic [15:0] pc,
                            input logic [7:0] opc, input logic [7:0] b, input logic [7:0] c);
      send_word(OP_WRITE, 2'($urandom), pc, opc, 16'($urandom));
      send_word(OP_WRITE, 2'($urandom), pc + 16'd1, b, 16'($urandom));
      send_word(OP_WRITE, 2'($urandom), pc + 16'd2, c, 16'($urandom));
      send_word(OP_STEP, k, 16'($urandom), 8'($urandom), 16'($urandom));
   endtask

   task automatic noise_word();
      int sel;
      sel = $urandom_range(0, 9);
      if (sel < 4)
         send_word(OP_WRITE, 2'($urandom), 16'($urandom), 8'($urandom), 16'($urandom));
      else if (sel < 9)
         send_word(OP_READ, 2'($urandom), 16'($urandom), 8'($urandom), 16'($urandom));
      else
         send_word(2'd3, 2'($urandom), 16'($urandom), 8'($urandom), 16'($urandom));
   endtask

   task automatic random_instr(input logic [1:0] k, input logic [15:0] pc);
      logic [7:0] opc;
      logic [3:0] divisor;
      int         sel;
      sel = $urandom_range(0, 99);
      if (sel < 8) begin
         // divisor loaded non-zero first so the core survives
         divisor = 4'($urandom);
         put_instr(k, pc, OPC_LDI, {divisor, 4'($urandom)}, 8'($urandom_range(1, 255)));
         put_instr(k, pc + 16'd3, (sel < 4) ? OPC_DIVU : OPC_DIVS, 8'($urandom),
                   {4'($urandom), divisor});
      end else begin
         opc = 8'($urandom_range(0, 41));
         if (opc == OPC_DIVU || opc == OPC_DIVS) opc = OPC_LDHI;
         put_instr(k, pc, opc, 8'($urandom), 8'($urandom));
      end
   endtask

   task automatic step_burst();
      logic [15:0] start_pc [4];
      int          first, count;
      logic [1:0]  k;
      drain();
      for (int i = 0; i < 4; i++) start_pc[i] = pc_now[i];
      first = $urandom_range(0, 3);
      count = $urandom_range(1, 4);
      for (int i = 0; i < count; i++) begin
         k = 2'(first + i);
         if ($urandom_range(0, 2) == 0) noise_word();
         random_instr(k, start_pc[k]);
      end
   endtask

   initial begin
      logic [15:0] p;
      clock = 1'b0;
      reset = 1'b1;
      csr_we = 1'b0;
      csr_wdata = 3'd0;
      calm = 1'b0;
      hold_request = 1'b0;
      sent = 0;
      req_if.valid = 1'b0;
      req_if.op = OP_STEP;
      req_if.core = 2'd0;
      req_if.address = 16'd0;
      req_if.data = 8'd0;
      req_if.port_read_data = 16'd0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed: field extremes, ignored op, fetch wrap, signed divide overflow
      send_word(OP_WRITE, 2'd0, 16'hffff, 8'hff, 16'h0000);
      send_word(OP_READ, 2'd3, 16'hffff, 8'h00, 16'hffff);
      send_word(OP_READ, 2'd0, 16'h0000, 8'hff, 16'h0000);
      send_word(2'd3, 2'd3, 16'hffff, 8'hff, 16'hffff);
      put_instr(2'd0, 16'h0000, OPC_JMP, 8'hff, 8'hfe);
      put_instr(2'd0, 16'hfffe, OPC_ADDI, 8'h12, 8'hff);
      put_instr(2'd1, 16'd0, OPC_LDI, 8'h10, 8'h80);
      put_instr(2'd1, 16'd3, OPC_LDHI, 8'h10, 8'h00);
      put_instr(2'd1, 16'd6, OPC_LDI, 8'h20, 8'hff);
      put_instr(2'd1, 16'd9, OPC_LDHI, 8'h20, 8'hff);
      put_instr(2'd1, 16'd12, OPC_DIVS, 8'h56, 8'h12);
      write_core_count(3'd1);
      put_instr(2'd2, 16'd0, OPC_CORECNT, 8'h30, 8'h00);
      put_instr(2'd3, 16'd0, OPC_IN, 8'h40, 8'hff);
      put_instr(2'd3, 16'd3, OPC_OUT, 8'h40, 8'h00);

      write_core_count(3'd3);
      while (sent < ITEM_TARGET / 3) step_burst();

      // long stall on the result side while words keep coming
      drain();
      hold_request = 1'b1;
      repeat (14) noise_word();
      write_core_count(3'd2);
      while (sent < 2 * ITEM_TARGET / 3) step_burst();
      write_core_count(3'd4);
      while (sent < ITEM_TARGET) step_burst();

      // no idling from here; freeze every core by a fault: illegal, divide by zero, requested
      calm = 1'b1;
      drain();
      put_instr(2'd0, pc_now[0], 8'($urandom_range(43, 255)), 8'($urandom), 8'($urandom));
      drain();
      p = pc_now[1];
      put_instr(2'd1, p, OPC_LDI, 8'h70, 8'h00);
      put_instr(2'd1, p + 16'd3, OPC_DIVU, 8'h12, 8'h37);
      drain();
      put_instr(2'd2, pc_now[2], OPC_FAULT, 8'($urandom), 8'($urandom));
      drain();
      p = pc_now[3];
      put_instr(2'd3, p, OPC_LDI, 8'h90, 8'h00);
      put_instr(2'd3, p + 16'd3, OPC_DIVS, 8'h12, 8'h39);
      drain();
      put_instr(2'd0, pc_now[0], 8'hff, 8'h00, 8'h00);
      for (int i = 0; i < 8; i++) begin
         send_word(OP_STEP, 2'(i), 16'($urandom), 8'($urandom), 16'($urandom));
         noise_word();
      end

      drain();
      repeat (60) @(posedge clock);
      if (failures == 0 && backlog == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule

// ----- sim.f -----
+incdir+design
design/rvcs_pkg.sv
design/rvcs_channels.sv
design/rvcs_front.sv
design/rvcs_queue.sv
design/rvcs_div.sv
design/rvcs_back.sv
design/register_vm_core_step_unit.sv
verif/rvcs_step_checker.sv
verif/tb_register_vm_core_step_unit.sv
